// ===== rtl/stmm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the segment tree range min/max core.
// No dependencies; imported by every module of the block.
package stmm_pkg;

  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned VAL_W      = 20;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned NODE_AW    = 11;
  localparam int unsigned NODE_COUNT = 2 * MAX_POINTS;
  // Walk indices can reach 2*MAX_POINTS on an empty range at the top.
  localparam int unsigned WALK_W     = NODE_AW + 1;

  localparam logic [VAL_W-1:0] EMPTY_MIN = VAL_W'(1000000);

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] lo;
  } node_t;

  // Neutral element of the combine: leaves max and min untouched.
  localparam node_t NODE_IDENT = '{hi: '0, lo: '1};
  localparam node_t NODE_EMPTY = '{hi: '0, lo: EMPTY_MIN};

  typedef struct packed {
    logic use_a;
    logic use_b;
  } unit_en_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLD_RD,
    ST_BLD_WR,
    ST_QRY_RUN,
    ST_QRY_END
  } stmm_state_e;

endpackage

// ===== rtl/stmm_node_ram.sv =====
`timescale 1ns / 1ps
// Node store: max and min of every tree node in one word, one write port
// and two registered read ports. Depends on stmm_pkg.
module stmm_node_ram
  import stmm_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [NODE_AW-1:0] waddr_i,
  input  node_t              wdata_i,
  input  logic [NODE_AW-1:0] raddr0_i,
  input  logic [NODE_AW-1:0] raddr1_i,
  output node_t              rdata0_o,
  output node_t              rdata1_o
);

  node_t mem [NODE_COUNT];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

// ===== rtl/stmm_minmax_unit.sv =====
`timescale 1ns / 1ps
// Shared combine unit: folds up to two node words into an accumulator,
// max on the hi half and min on the lo half. Depends on stmm_pkg.
module stmm_minmax_unit
  import stmm_pkg::*;
(
  input  node_t    acc_i,
  input  node_t    a_i,
  input  node_t    b_i,
  input  unit_en_t en_i,
  output node_t    res_o
);

  node_t a_m;
  node_t b_m;
  node_t ab;

  // Replace unused operands with the neutral element.
  assign a_m = en_i.use_a ? a_i : NODE_IDENT;
  assign b_m = en_i.use_b ? b_i : NODE_IDENT;

  assign ab.hi    = (a_m.hi > b_m.hi) ? a_m.hi : b_m.hi;
  assign ab.lo    = (a_m.lo < b_m.lo) ? a_m.lo : b_m.lo;
  assign res_o.hi = (acc_i.hi > ab.hi) ? acc_i.hi : ab.hi;
  assign res_o.lo = (acc_i.lo < ab.lo) ? acc_i.lo : ab.lo;

endmodule

// ===== rtl/segment_tree_range_min_max_core.sv =====
`timescale 1ns / 1ps
// Top level of the segment tree range min/max core: sequencer, walk indices,
// configuration register. Depends on stmm_pkg, stmm_node_ram, stmm_minmax_unit.
//
// A request is taken when start is high and busy is low. A leaf write never
// raises busy. A build visits each internal node from N-1 down to 1, with a read
// state and a write state per node through the single node RAM write port. A
// query holds busy while the walk climbs the tree level by level from both
// ends of the range, then folds the last node reads and loads the result;
// both ends of the range are read in the same cycle on the two RAM read
// ports. The result appears on range_max_o, range_min_o and bad_range_o
// with done_o high for exactly one cycle, the cycle in which busy falls;
// the receiver cannot stall it. A bad or empty range answers in the cycle
// after it is taken, without raising busy.
// Configuration writes are taken whenever the core is not busy.
module segment_tree_range_min_max_core
  import stmm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [VAL_W-1:0]   point_value_i,
  input  logic [CNT_W-1:0]   range_left_i,
  input  logic [CNT_W-1:0]   range_right_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CNT_W-1:0]   cfg_data_i,
  output logic [VAL_W-1:0]   range_max_o,
  output logic [VAL_W-1:0]   range_min_o,
  output logic               bad_range_o,
  output logic               done_o
);

  stmm_state_e state_q, state_d;

  logic [CNT_W-1:0]  cfg_q;
  logic [CNT_W-1:0]  n_eff;
  logic [POS_W-1:0]  k_q, k_d;
  logic [WALK_W-1:0] l_q, l_d, r_q, r_d;
  logic [WALK_W-1:0] l_inc, r_dec, r_m1;
  node_t             acc_q, acc_d;
  unit_en_t          take_q, take_d;
  node_t             out_q, out_d;
  logic              bad_q, bad_d;
  logic              done_q, done_d;

  logic              accept;
  logic              range_bad;
  logic              pos_ok;
  logic [CNT_W-1:0]  k_init;

  logic              ram_we;
  logic [NODE_AW-1:0] ram_waddr, ram_raddr0, ram_raddr1;
  node_t             ram_wdata, rd0, rd1;

  node_t             unit_acc, unit_res;
  unit_en_t          unit_en;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy;
  assign accept      = start && !busy;

  // Clamp the count to 1..MAX_POINTS.
  always_comb begin
    if (cfg_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (cfg_q > CNT_W'(MAX_POINTS)) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = cfg_q;
    end
  end

  assign range_bad = (range_left_i > range_right_i) || (range_right_i > n_eff);
  assign pos_ok    = ({1'b0, position_i} < n_eff);
  assign k_init    = n_eff - CNT_W'(1);

  assign l_inc = l_q + {{(WALK_W-1){1'b0}}, l_q[0]};
  assign r_dec = r_q - {{(WALK_W-1){1'b0}}, r_q[0]};
  assign r_m1  = r_q - WALK_W'(1);

  stmm_node_ram u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr0_i (ram_raddr0),
    .raddr1_i (ram_raddr1),
    .rdata0_o (rd0),
    .rdata1_o (rd1)
  );

  stmm_minmax_unit u_unit (
    .acc_i (unit_acc),
    .a_i   (rd0),
    .b_i   (rd1),
    .en_i  (unit_en),
    .res_o (unit_res)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_BUILD: if (n_eff != CNT_W'(1)) state_d = ST_BLD_RD;
            MODE_QUERY: begin
              if (!range_bad && (range_left_i != range_right_i)) state_d = ST_QRY_RUN;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_BLD_RD:  state_d = ST_BLD_WR;
      ST_BLD_WR:  state_d = (k_q == POS_W'(1)) ? ST_IDLE : ST_BLD_RD;
      ST_QRY_RUN: state_d = (l_q == r_q) ? ST_QRY_END : ST_QRY_RUN;
      ST_QRY_END: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    k_d        = k_q;
    l_d        = l_q;
    r_d        = r_q;
    acc_d      = acc_q;
    take_d     = '0;
    out_d      = out_q;
    bad_d      = bad_q;
    done_d     = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = n_eff + {1'b0, position_i};
    ram_wdata  = '{hi: point_value_i, lo: point_value_i};
    ram_raddr0 = l_q[NODE_AW-1:0];
    ram_raddr1 = r_m1[NODE_AW-1:0];
    unit_acc   = acc_q;
    unit_en    = take_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_WRITE: ram_we = pos_ok;
            MODE_BUILD: k_d = k_init[POS_W-1:0];
            MODE_QUERY: begin
              l_d   = {1'b0, range_left_i} + {1'b0, n_eff};
              r_d   = {1'b0, range_right_i} + {1'b0, n_eff};
              acc_d = NODE_EMPTY;
              // Bad or empty range: answer without touching the tree.
              if (range_bad || (range_left_i == range_right_i)) begin
                out_d  = NODE_EMPTY;
                bad_d  = range_bad;
                done_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_BLD_RD: begin
        ram_raddr0 = {k_q, 1'b0};
        ram_raddr1 = {k_q, 1'b1};
      end
      ST_BLD_WR: begin
        unit_acc  = NODE_IDENT;
        unit_en   = '{use_a: 1'b1, use_b: 1'b1};
        ram_we    = 1'b1;
        ram_waddr = {1'b0, k_q};
        ram_wdata = unit_res;
        k_d       = k_q - POS_W'(1);
      end
      ST_QRY_RUN: begin
        // Fold last cycle's reads; issue this level's reads and climb.
        acc_d = unit_res;
        if (l_q != r_q) begin
          take_d = '{use_a: l_q[0], use_b: r_q[0]};
          l_d    = {1'b0, l_inc[WALK_W-1:1]};
          r_d    = {1'b0, r_dec[WALK_W-1:1]};
        end
      end
      ST_QRY_END: begin
        out_d  = unit_res;
        bad_d  = 1'b0;
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cfg_q   <= CNT_W'(MAX_POINTS);
      take_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      take_q  <= take_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    l_q   <= l_d;
    r_q   <= r_d;
    acc_q <= acc_d;
    out_q <= out_d;
    bad_q <= bad_d;
  end

  assign range_max_o = out_q.hi;
  assign range_min_o = out_q.lo;
  assign bad_range_o = bad_q;
  assign done_o      = done_q;

endmodule

// ===== test/stmm_query_checker.sv =====
`timescale 1ns / 1ps
// Checker for segment_tree_range_min_max_core: keeps its own max/min node trees
// and point count, predicts each query answer and compares it on done_o.
// Depends on stmm_pkg only; instantiated by tb beside the core.
module stmm_query_checker
  import stmm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         mode_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [VAL_W-1:0]   point_value_i,
  input  logic [CNT_W-1:0]   range_left_i,
  input  logic [CNT_W-1:0]   range_right_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CNT_W-1:0]   cfg_data_i,
  input  logic [VAL_W-1:0]   range_max_i,
  input  logic [VAL_W-1:0]   range_min_i,
  input  logic               bad_range_i,
  input  logic               done_i,
  output int                 answers_due_o,
  output int                 fails_o,
  output int                 answers_seen_o
);

  typedef struct packed {
    logic [VAL_W-1:0] peak;
    logic [VAL_W-1:0] trough;
    logic             bad;
  } span_answer_t;

  logic [VAL_W-1:0] peak_tree   [NODE_COUNT];
  logic [VAL_W-1:0] trough_tree [NODE_COUNT];
  logic [CNT_W-1:0] points_reg;
  span_answer_t     answers_q [$];
  int               mismatches = 0;
  int               seen = 0;

  function automatic int unsigned live_points();
    if (points_reg == '0) return 1;
    if (points_reg > MAX_POINTS) return MAX_POINTS;
    return points_reg;
  endfunction

  function automatic void rebuild_trees();
    int unsigned n;
    n = live_points();
    for (int unsigned k = n - 1; k > 0; k--) begin
      peak_tree[k] = (peak_tree[2*k] > peak_tree[2*k+1]) ? peak_tree[2*k] : peak_tree[2*k+1];
      trough_tree[k] = (trough_tree[2*k] < trough_tree[2*k+1]) ?
                       trough_tree[2*k] : trough_tree[2*k+1];
    end
  endfunction

  function automatic void merge_node(input int unsigned k, inout span_answer_t acc);
    if (peak_tree[k] > acc.peak) acc.peak = peak_tree[k];
    if (trough_tree[k] < acc.trough) acc.trough = trough_tree[k];
  endfunction

  function automatic span_answer_t span_of(input int unsigned left, input int unsigned right);
    int unsigned  n;
    int unsigned  lo_i;
    int unsigned  hi_i;
    span_answer_t acc;
    n = live_points();
    acc = '{peak: '0, trough: EMPTY_MIN, bad: 1'b0};
    if (left > right || right > n) begin
      acc.bad = 1'b1;
      return acc;
    end
    lo_i = left + n;
    hi_i = right + n;
    // climb from both ends, folding in the nodes that stick out of the span
    while (lo_i != hi_i) begin
      if (lo_i & 1) begin
        merge_node(lo_i, acc);
        lo_i++;
      end
      if (hi_i & 1) begin
        hi_i--;
        merge_node(hi_i, acc);
      end
      lo_i >>= 1;
      hi_i >>= 1;
    end
    return acc;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    span_answer_t want;
    if (!rst_ni) begin
      answers_q.delete();
      points_reg = CNT_W'(MAX_POINTS);
      answers_due_o <= 0;
      fails_o <= 0;
      answers_seen_o <= 0;
    end else begin
      // check the answer on the wires before taking a new request
      if (done_i) begin
        if (answers_q.size() == 0) begin
          $display("%0t: answer with none expected: max %0d min %0d bad %0b",
                   $time, range_max_i, range_min_i, bad_range_i);
          mismatches++;
        end else begin
          want = answers_q.pop_front();
          seen++;
          if (range_max_i !== want.peak) begin
            $display("%0t: range_max expected %0d, got %0d", $time, want.peak, range_max_i);
            mismatches++;
          end
          if (range_min_i !== want.trough) begin
            $display("%0t: range_min expected %0d, got %0d", $time, want.trough, range_min_i);
            mismatches++;
          end
          if (bad_range_i !== want.bad) begin
            $display("%0t: bad_range expected %0b, got %0b", $time, want.bad, bad_range_i);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) begin
        case (mode_i)
          MODE_WRITE: begin
            if (position_i < live_points()) begin
              peak_tree[live_points() + position_i] = point_value_i;
              trough_tree[live_points() + position_i] = point_value_i;
            end
          end
          MODE_BUILD: rebuild_trees();
          MODE_QUERY: answers_q.push_back(span_of(range_left_i, range_right_i));
          default: ;
        endcase
      end
      if (cfg_valid_i && cfg_ready_i) points_reg = cfg_data_i;
      answers_due_o <= answers_q.size();
      fails_o <= mismatches;
      answers_seen_o <= seen;
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for segment_tree_range_min_max_core: drives leaf writes, builds,
// range queries and point-count changes, and prints the verdict.
// Depends on stmm_pkg, the core RTL and stmm_query_checker.
module tb;
  import stmm_pkg::*;

  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam int unsigned VAL_TOP     = 999999;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         mode_i = MODE_WRITE;
  logic [POS_W-1:0]   position_i = '0;
  logic [VAL_W-1:0]   point_value_i = '0;
  logic [CNT_W-1:0]   range_left_i = '0;
  logic [CNT_W-1:0]   range_right_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CNT_W-1:0]   cfg_data_i = '0;
  logic [VAL_W-1:0]   range_max_o;
  logic [VAL_W-1:0]   range_min_o;
  logic               bad_range_o;
  logic               done_o;

  int answers_due;
  int chk_fails;
  int answers_seen;

  int unsigned live_n = MAX_POINTS;  // point count as the core applies it
  int unsigned built_span = 0;       // nodes 1 .. 2*built_span-1 all hold data
  int unsigned idle_pct = 0;
  int unsigned n_write = 0;
  int unsigned n_build = 0;
  int unsigned n_query = 0;
  int unsigned n_unused = 0;
  int unsigned n_cfg = 0;

  segment_tree_range_min_max_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .position_i    (position_i),
    .point_value_i (point_value_i),
    .range_left_i  (range_left_i),
    .range_right_i (range_right_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .range_max_o   (range_max_o),
    .range_min_o   (range_min_o),
    .bad_range_o   (bad_range_o),
    .done_o        (done_o)
  );

  stmm_query_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .mode_i         (mode_i),
    .position_i     (position_i),
    .point_value_i  (point_value_i),
    .range_left_i   (range_left_i),
    .range_right_i  (range_right_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .range_max_i    (range_max_o),
    .range_min_i    (range_min_o),
    .bad_range_i    (bad_range_o),
    .done_i         (done_o),
    .answers_due_o  (answers_due),
    .fails_o        (chk_fails),
    .answers_seen_o (answers_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("== FAIL ==");
    $finish;
  end

  // Offer one request and hold it until the core takes it.
  task automatic issue(input logic [1:0] m, input int unsigned pos, input int unsigned val,
                       input int unsigned left, input int unsigned right);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    mode_i <= m;
    position_i <= POS_W'(pos);
    point_value_i <= VAL_W'(val);
    range_left_i <= CNT_W'(left);
    range_right_i <= CNT_W'(right);
    do @(posedge clk_i); while (busy);
    case (m)
      MODE_WRITE: n_write++;
      MODE_BUILD: n_build++;
      MODE_QUERY: n_query++;
      default:    n_unused++;
    endcase
  endtask

  function automatic int unsigned some_value();
    case ($urandom_range(9))
      0:       return 0;
      1:       return VAL_TOP;
      default: return $urandom_range(VAL_TOP);
    endcase
  endfunction

  task automatic ask_range(input int unsigned left, input int unsigned right);
    issue(MODE_QUERY, $urandom, some_value(), left, right);
  endtask

  // Change the point count only once the core is idle and no answer is owed.
  task automatic set_points(input int unsigned v);
    start <= 1'b0;
    do @(posedge clk_i); while (busy || answers_due != 0);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= CNT_W'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    live_n = (v == 0) ? 1 : ((v > MAX_POINTS) ? MAX_POINTS : v);
    n_cfg++;
  endtask

  task automatic fill_leaves();
    for (int unsigned i = 0; i < live_n; i++) issue(MODE_WRITE, i, some_value(), $urandom, $urandom);
    issue(MODE_BUILD, $urandom, some_value(), $urandom, $urandom);
    if (live_n > built_span) built_span = live_n;
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned sel;
    int unsigned left;
    int unsigned right;
    pick = $urandom_range(99);
    if (pick < 35) begin
      issue(MODE_WRITE, $urandom_range(live_n - 1), some_value(), $urandom, $urandom);
    end else if (pick < 40) begin
      // any position: past the count the write is dropped
      issue(MODE_WRITE, $urandom_range(1023), some_value(), $urandom, $urandom);
    end else if (pick < 50) begin
      issue(MODE_BUILD, $urandom, some_value(), $urandom, $urandom);
    end else if (pick < 95) begin
      sel = $urandom_range(19);
      if (sel == 0) begin
        ask_range(0, live_n);
      end else if (sel == 1) begin
        left = $urandom_range(live_n, 1);
        ask_range(left, $urandom_range(left - 1));
      end else if (sel == 2) begin
        ask_range($urandom_range(2047), $urandom_range(2047, live_n + 1));
      end else begin
        left = $urandom_range(live_n);
        right = $urandom_range(live_n, left);
        ask_range(left, right);
      end
    end else begin
      issue(MODE_UNUSED, $urandom, some_value(), $urandom, $urandom);
    end
  endtask

  initial begin
    int unsigned budget;
    int unsigned seg;
    int unsigned pts;
    int unsigned waited;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset count is the full tree: these read no node
    ask_range(0, MAX_POINTS + 1);
    ask_range(MAX_POINTS, MAX_POINTS);
    ask_range(7, 3);
    issue(MODE_UNUSED, 1023, VAL_TOP, 2047, 2047);

    set_points(8);
    fill_leaves();
    issue(MODE_WRITE, 0, 0, 0, 0);
    issue(MODE_WRITE, 7, VAL_TOP, 0, 0);
    issue(MODE_WRITE, 8, 12345, 0, 0);
    issue(MODE_WRITE, 1023, VAL_TOP, 0, 0);
    issue(MODE_BUILD, 0, 0, 0, 0);
    ask_range(0, 8);
    ask_range(3, 4);
    ask_range(7, 8);
    ask_range(5, 5);
    ask_range(0, 9);
    ask_range(6, 2);

    // shrink the count over the built tree without rebuilding
    set_points(0);
    ask_range(0, 1);
    ask_range(0, 2);
    set_points(3);
    ask_range(0, 3);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 30 : ((ph == 1) ? 87 : 0);
      budget = 0;
      while (budget < 185) begin
        if (budget == 0) begin
          pts = (ph == 0) ? 1024 : ((ph == 1) ? 2047 : 1025);
        end else begin
          case ($urandom_range(9))
            0:       pts = 0;
            1:       pts = $urandom_range(1023, 41);
            2:       pts = $urandom_range(2047, 1024);
            default: pts = $urandom_range(40, 1);
          endcase
        end
        set_points(pts);
        // a grown count needs every node rewritten before any query
        if (live_n > built_span || (live_n <= 64 && $urandom_range(1) == 1)) fill_leaves();
        seg = $urandom_range(50, 20);
        repeat (seg) random_item();
        budget += seg;
      end
    end

    start <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk_i);
      waited++;
    end while ((busy || answers_due != 0) && waited < 20000);
    repeat (16) @(posedge clk_i);

    if (answers_due != 0) $display("%0t: %0d expected answers never arrived", $time, answers_due);
    $display("Ran %0d leaf writes, %0d builds, %0d range queries, %0d unused-mode requests",
             n_write, n_build, n_query, n_unused);
    $display("across %0d point-count settings; %0d answers compared", n_cfg, answers_seen);
    if (chk_fails == 0 && answers_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/stmm_pkg.sv
rtl/stmm_node_ram.sv
rtl/stmm_minmax_unit.sv
rtl/segment_tree_range_min_max_core.sv
test/stmm_query_checker.sv
test/tb.sv
